@@ rtl/core/thermal_pixel_stretch_and_palette_core_macros.svh @@
// Assertion macros shared by the thermal pixel stretch and palette RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef THERMAL_PIXEL_STRETCH_AND_PALETTE_CORE_MACROS_SVH
`define THERMAL_PIXEL_STRETCH_AND_PALETTE_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define TPSP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define TPSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TPSP_ASSERT_IMPL(label, ante, cons, msg)
`define TPSP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/core/tpsp_pkg.sv @@
// Package for the thermal pixel stretch and palette block: widths, codes, types.
// Depends on nothing.
package tpsp_pkg;

    localparam int PIXEL_BITS_DEFAULT = 16;
    localparam int CFG_DATA_BITS      = 16;
    localparam int CFG_INDEX_BITS     = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_HIGH = 2'd1;

    localparam logic [CFG_DATA_BITS-1:0] RANGE_LOW_RESET  = 16'd1230;
    localparam logic [CFG_DATA_BITS-1:0] RANGE_HIGH_RESET = 16'd1500;

    // Divider operand widths; the largest denominator is 9 times the range.
    localparam int NUM_BITS       = 28;
    localparam int DEN_BITS       = 20;
    localparam int QUO_BITS       = 8;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_BITS / BITS_PER_STAGE;

    typedef enum logic [1:0] {GRAY_ZERO, GRAY_FULL, GRAY_DIV} gray_sel_t;
    typedef enum logic [1:0] {RED_ZERO, RED_DIV, RED_FULL} red_sel_t;
    typedef enum logic [2:0] {
        GREEN_ZERO, GREEN_RISE_LOW, GREEN_RISE_HIGH, GREEN_FULL, GREEN_FALL
    } green_sel_t;
    typedef enum logic [1:0] {BLUE_ZERO, BLUE_RISE, BLUE_FALL} blue_sel_t;

    typedef struct packed {
        gray_sel_t  gray_sel;
        red_sel_t   red_sel;
        green_sel_t green_sel;
        blue_sel_t  blue_sel;
    } side_t;

endpackage

@@ rtl/core/tpsp_if.sv @@
// Channel interfaces of the thermal pixel stretch and palette block.
// Depends on tpsp_pkg.
interface tpsp_pixel_if #(parameter int PIXEL_BITS = tpsp_pkg::PIXEL_BITS_DEFAULT);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_count;
    modport source (output valid, pixel_count, input ready);
    modport sink   (input valid, pixel_count, output ready);
endinterface

interface tpsp_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] gray_level;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    modport source (output valid, gray_level, red_level, green_level, blue_level,
                    input ready);
    modport sink   (input valid, gray_level, red_level, green_level, blue_level,
                    output ready);
endinterface

interface tpsp_cfg_if;
    import tpsp_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/tpsp_div_pipe.sv @@
// Pipelined restoring divider giving an 8-bit quotient, two bits per stage.
// Depends on tpsp_pkg. The quotient must be known to fit in QUO_BITS.
module tpsp_div_pipe (
    input  logic                          clk,
    input  logic                          en,
    input  logic [tpsp_pkg::NUM_BITS-1:0] num,
    input  logic [tpsp_pkg::DEN_BITS-1:0] den,
    output logic [tpsp_pkg::QUO_BITS-1:0] quo
);
    import tpsp_pkg::*;

    logic [NUM_BITS-1:0] rem_reg [DIV_STAGES];
    logic [DEN_BITS-1:0] den_reg [DIV_STAGES];
    logic [QUO_BITS-1:0] quo_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [NUM_BITS-1:0] rem_in;
        logic [DEN_BITS-1:0] den_in;
        logic [QUO_BITS-1:0] quo_in;
        logic [NUM_BITS-1:0] rem_next;
        logic [QUO_BITS-1:0] quo_next;

        if (s == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        always_comb
        begin
            logic [NUM_BITS-1:0] shifted;
            rem_next = rem_in;
            quo_next = quo_in;
            for (int j = 0; j < BITS_PER_STAGE; j++)
            begin
                shifted = NUM_BITS'(den_in) << (QUO_BITS - 1 - s * BITS_PER_STAGE - j);
                if (rem_next >= shifted)
                begin
                    rem_next = rem_next - shifted;
                    quo_next[QUO_BITS - 1 - s * BITS_PER_STAGE - j] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_in;
                quo_reg[s] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

@@ rtl/core/thermal_pixel_stretch_and_palette_core.sv @@
// Top level of the thermal pixel stretch and palette block.
// Depends on tpsp_pkg, the channel interfaces in tpsp_if and tpsp_div_pipe.
//
// Usage: raw thermal counts arrive one item at a time on the pixel channel
// and leave as an 8-bit gray value plus an RGB pseudocolor on the result
// channel, exactly one result item per pixel item, in order. Both channels
// use valid/ready; an item moves at a rising edge with valid and ready high.
// The cfg channel writes range_low_count (index 0) and range_high_count
// (index 1); it is always ready, writes to other indexes are dropped, and it
// should only be used while no pixel is in flight.
// Throughput is one item per cycle while results are taken. From acceptance,
// an item passes the offset and breakpoint compare registers, the register
// building numerators and denominators, the divider stages (two quotient
// bits per stage), and the output register, where its result is presented.
// Reset clears all valid bits and loads the range registers with 1230 and
// 1500. When the receiver stalls, the whole pipeline freezes in place, so
// pixel.ready drops only while a finished result is waiting and not taken.
module thermal_pixel_stretch_and_palette_core #(
    parameter int PIXEL_BITS = tpsp_pkg::PIXEL_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    tpsp_pixel_if.sink    pixel,
    tpsp_result_if.source result,
    tpsp_cfg_if.sink      cfg
);
    import tpsp_pkg::*;

`include "thermal_pixel_stretch_and_palette_core_macros.svh"

    // Wide enough for 27 times the offset and for 27 times the range.
    localparam int DW = (PIXEL_BITS + 7 > 24) ? PIXEL_BITS + 7 : 24;
    localparam int SIDE_DEPTH = DIV_STAGES + 1;

    // Configuration registers.
    logic [CFG_DATA_BITS-1:0] range_low_reg;
    logic [CFG_DATA_BITS-1:0] range_high_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= RANGE_LOW_RESET;
            range_high_reg <= RANGE_HIGH_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_RANGE_LOW:  range_low_reg  <= cfg.data;
                REG_RANGE_HIGH: range_high_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // The pipeline advances as a whole unless a result sits unclaimed.
    logic en;
    logic vo_reg;

    assign en          = !vo_reg || result.ready;
    assign pixel.ready = en;

    // Stage A: offset scaled by 27, range multiples, gray decision.
    logic signed [DW-1:0] v_ext, lo_ext, hi_ext, diff_a, d_a;
    logic signed [17:0]   r_a;
    logic signed [DW-1:0] r_ext;
    gray_sel_t            gray_sel_a;

    assign v_ext  = $signed({{(DW-PIXEL_BITS){1'b0}}, pixel.pixel_count});
    assign lo_ext = $signed({{(DW-CFG_DATA_BITS){1'b0}}, range_low_reg});
    assign hi_ext = $signed({{(DW-CFG_DATA_BITS){1'b0}}, range_high_reg});
    assign diff_a = v_ext - lo_ext;
    assign d_a    = (diff_a <<< 4) + (diff_a <<< 3) + (diff_a <<< 1) + diff_a;
    assign r_a    = $signed({2'b00, range_high_reg}) - $signed({2'b00, range_low_reg});
    assign r_ext  = $signed({{(DW-18){r_a[17]}}, r_a});

    always_comb
    begin
        if (pixel.pixel_count == '0)
            gray_sel_a = GRAY_ZERO;
        else if (v_ext >= hi_ext)
            gray_sel_a = GRAY_FULL;
        else if (v_ext >= lo_ext)
            gray_sel_a = GRAY_DIV;
        else
            gray_sel_a = GRAY_ZERO;
    end

    logic                 va_reg;
    logic signed [DW-1:0] d_a_reg;
    logic signed [DW-1:0] r1_reg, r8_reg, r9_reg, r14_reg, r15_reg, r18_reg, r27_reg;
    logic [15:0]          vlo_a_reg;
    gray_sel_t            gray_sel_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= pixel.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_a_reg        <= d_a;
            r1_reg         <= r_ext;
            r8_reg         <= r_ext <<< 3;
            r9_reg         <= (r_ext <<< 3) + r_ext;
            r14_reg        <= (r_ext <<< 4) - (r_ext <<< 1);
            r15_reg        <= (r_ext <<< 4) - r_ext;
            r18_reg        <= (r_ext <<< 4) + (r_ext <<< 1);
            r27_reg        <= (r_ext <<< 4) + (r_ext <<< 3) + (r_ext <<< 1) + r_ext;
            vlo_a_reg      <= diff_a[15:0];
            gray_sel_a_reg <= gray_sel_a;
        end
    end

    // Stage B: find the palette segment and the offset into it.
    red_sel_t             red_sel_b;
    green_sel_t           green_sel_b;
    blue_sel_t            blue_sel_b;
    logic signed [DW-1:0] green_base, blue_base, t_red_b, t_green_b, t_blue_b;

    always_comb
    begin
        if (d_a_reg <= r14_reg)
            red_sel_b = RED_ZERO;
        else if (d_a_reg <= r18_reg)
            red_sel_b = RED_DIV;
        else
            red_sel_b = RED_FULL;

        green_base = r1_reg;
        if (d_a_reg <= r1_reg)
            green_sel_b = GREEN_ZERO;
        else if (d_a_reg <= r9_reg)
            green_sel_b = GREEN_RISE_LOW;
        else if (d_a_reg <= r14_reg)
        begin
            green_sel_b = GREEN_RISE_HIGH;
            green_base  = r9_reg;
        end
        else if (d_a_reg <= r18_reg)
            green_sel_b = GREEN_FULL;
        else if (d_a_reg <= r27_reg)
        begin
            green_sel_b = GREEN_FALL;
            green_base  = r18_reg;
        end
        else
            green_sel_b = GREEN_ZERO;

        blue_base = r1_reg;
        if (d_a_reg <= r1_reg)
            blue_sel_b = BLUE_ZERO;
        else if (d_a_reg <= r8_reg)
            blue_sel_b = BLUE_RISE;
        else if (d_a_reg <= r15_reg)
        begin
            blue_sel_b = BLUE_FALL;
            blue_base  = r8_reg;
        end
        else
            blue_sel_b = BLUE_ZERO;
    end

    assign t_red_b   = d_a_reg - r14_reg;
    assign t_green_b = d_a_reg - green_base;
    assign t_blue_b  = d_a_reg - blue_base;

    logic                vb_reg;
    logic [DEN_BITS-1:0] t_red_reg, t_green_reg, t_blue_reg;
    logic [15:0]         r_b_reg;
    logic [15:0]         vlo_b_reg;
    side_t               side_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_red_reg            <= t_red_b[DEN_BITS-1:0];
            t_green_reg          <= t_green_b[DEN_BITS-1:0];
            t_blue_reg           <= t_blue_b[DEN_BITS-1:0];
            r_b_reg              <= r1_reg[15:0];
            vlo_b_reg            <= vlo_a_reg;
            side_b_reg.gray_sel  <= gray_sel_a_reg;
            side_b_reg.red_sel   <= red_sel_b;
            side_b_reg.green_sel <= green_sel_b;
            side_b_reg.blue_sel  <= blue_sel_b;
        end
    end

    // Stage C: numerators and denominators. Falling ramps add den - 1 so the
    // floor division yields the ceiling.
    logic [DEN_BITS-1:0] r_c;
    logic [NUM_BITS-1:0] gray_num_c, red_num_c, green_num_c, blue_num_c;
    logic [DEN_BITS-1:0] red_den_c, green_den_c, blue_den_c;

    assign r_c        = DEN_BITS'(r_b_reg);
    assign gray_num_c = NUM_BITS'(vlo_b_reg) * NUM_BITS'(255);
    assign red_num_c  = NUM_BITS'(t_red_reg) * NUM_BITS'(255);
    assign red_den_c  = r_c << 2;

    always_comb
    begin
        case (side_b_reg.green_sel)
            GREEN_RISE_HIGH:
            begin
                green_num_c = NUM_BITS'(t_green_reg) * NUM_BITS'(155);
                green_den_c = (r_c << 2) + r_c;
            end
            GREEN_FALL:
            begin
                green_den_c = (r_c << 3) + r_c;
                green_num_c = NUM_BITS'(t_green_reg) * NUM_BITS'(255)
                            + NUM_BITS'(green_den_c) - NUM_BITS'(1);
            end
            default:
            begin
                green_num_c = NUM_BITS'(t_green_reg) * NUM_BITS'(100);
                green_den_c = r_c << 3;
            end
        endcase

        blue_den_c = (r_c << 3) - r_c;
        case (side_b_reg.blue_sel)
            BLUE_FALL:
                blue_num_c = NUM_BITS'(t_blue_reg) * NUM_BITS'(155)
                           + NUM_BITS'(blue_den_c) - NUM_BITS'(1);
            default:
                blue_num_c = NUM_BITS'(t_blue_reg) * NUM_BITS'(255);
        endcase
    end

    logic [NUM_BITS-1:0] gray_num_reg, red_num_reg, green_num_reg, blue_num_reg;
    logic [DEN_BITS-1:0] gray_den_reg, red_den_reg, green_den_reg, blue_den_reg;

    // Side codes and valid bits ride alongside stage C and the divider stages.
    logic  vld_reg  [SIDE_DEPTH];
    side_t side_reg [SIDE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SIDE_DEPTH; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= vb_reg;
            for (int i = 1; i < SIDE_DEPTH; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gray_num_reg  <= gray_num_c;
            gray_den_reg  <= r_c;
            red_num_reg   <= red_num_c;
            red_den_reg   <= red_den_c;
            green_num_reg <= green_num_c;
            green_den_reg <= green_den_c;
            blue_num_reg  <= blue_num_c;
            blue_den_reg  <= blue_den_c;
            side_reg[0]   <= side_b_reg;
            for (int i = 1; i < SIDE_DEPTH; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // Divider lanes, one per output channel.
    logic [QUO_BITS-1:0] gray_q, red_q, green_q, blue_q;

    tpsp_div_pipe u_div_gray (
        .clk (clk), .en (en), .num (gray_num_reg), .den (gray_den_reg), .quo (gray_q)
    );
    tpsp_div_pipe u_div_red (
        .clk (clk), .en (en), .num (red_num_reg), .den (red_den_reg), .quo (red_q)
    );
    tpsp_div_pipe u_div_green (
        .clk (clk), .en (en), .num (green_num_reg), .den (green_den_reg), .quo (green_q)
    );
    tpsp_div_pipe u_div_blue (
        .clk (clk), .en (en), .num (blue_num_reg), .den (blue_den_reg), .quo (blue_q)
    );

    // Output stage: turn quotients into levels for the chosen segment.
    side_t      side_o;
    logic [7:0] gray_next, red_next, green_next, blue_next;

    assign side_o = side_reg[SIDE_DEPTH-1];

    always_comb
    begin
        case (side_o.gray_sel)
            GRAY_FULL: gray_next = 8'd255;
            GRAY_DIV:  gray_next = gray_q;
            default:   gray_next = 8'd0;
        endcase

        case (side_o.red_sel)
            RED_FULL: red_next = 8'd255;
            RED_DIV:  red_next = red_q;
            default:  red_next = 8'd0;
        endcase

        case (side_o.green_sel)
            GREEN_RISE_LOW:  green_next = green_q;
            GREEN_RISE_HIGH: green_next = 8'd100 + green_q;
            GREEN_FULL:      green_next = 8'd255;
            GREEN_FALL:      green_next = 8'd255 - green_q;
            default:         green_next = 8'd0;
        endcase

        case (side_o.blue_sel)
            BLUE_RISE: blue_next = blue_q;
            BLUE_FALL: blue_next = 8'd255 - blue_q;
            default:   blue_next = 8'd0;
        endcase
    end

    logic [7:0] gray_reg, red_reg, green_reg, blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= vld_reg[SIDE_DEPTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gray_reg  <= gray_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign result.valid       = vo_reg;
    assign result.gray_level  = gray_reg;
    assign result.red_level   = red_reg;
    assign result.green_level = green_reg;
    assign result.blue_level  = blue_reg;

    // An accepted pixel must show up in the first stage.
    `TPSP_ASSERT_NEXT(a_accept_enters, pixel.valid && pixel.ready, va_reg, "pixel lost at entry")
    // A frozen pipeline keeps its valid bits.
    `TPSP_ASSERT_NEXT(a_stall_holds, !en, $stable(vb_reg) && $stable(vld_reg[SIDE_DEPTH-1]), "valid moved during stall")
    // A saturated red segment must come out as full red.
    `TPSP_ASSERT_NEXT(a_red_full, en && vld_reg[SIDE_DEPTH-1] && side_o.red_sel == RED_FULL, red_reg == 8'd255, "red saturation wrong")
    // A pixel below the range or zero gives black gray.
    `TPSP_ASSERT_NEXT(a_gray_zero, en && vld_reg[SIDE_DEPTH-1] && side_o.gray_sel == GRAY_ZERO, gray_reg == 8'd0, "gray zero wrong")

endmodule
